// File: hdl/kmc_pkg.sv
// kmc_pkg: shared types, codes and helpers of the k-mer occurrence counter.
// Used by kmc_front, kmc_queue, kmc_back and kmer_occurrence_counter.
`default_nettype none
package kmc_pkg;

  localparam int MAX_KMER_LEN = 8;
  localparam int COUNT_BITS   = 32;
  localparam int INDEX_BITS   = 16;
  localparam int TALLY_BITS   = 17;
  localparam int LEN_BITS     = 4;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [LEN_BITS-1:0]   KMER_LEN_RESET = LEN_BITS'(8);

  // request types at the input
  localparam logic [1:0] REQ_BASE  = 2'd0;
  localparam logic [1:0] REQ_QUERY = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // operations handed from front to back
  localparam logic [1:0] OP_COUNT = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]            op;
    logic [INDEX_BITS-1:0] addr;
  } kmc_op_t;

  typedef struct packed {
    logic init_sweep;  // clearing pass after reset
    logic sweeping;    // any clearing pass
  } kmc_back_stat_t;

  // map a base byte to its 2-bit code; bit 2 flags an invalid byte
  function automatic logic [2:0] base_code(input logic [7:0] ch);
    logic [2:0] c;
    case (ch)
      8'h41:   c = 3'd0;
      8'h43:   c = 3'd1;
      8'h47:   c = 3'd2;
      8'h54:   c = 3'd3;
      default: c = 3'd4;
    endcase
    return c;
  endfunction

  // clamp the configured length to 1..MAX_KMER_LEN
  function automatic logic [LEN_BITS-1:0] eff_len(input logic [LEN_BITS-1:0] k);
    logic [LEN_BITS-1:0] r;
    r = k;
    if (r == '0) r = LEN_BITS'(1);
    if (r > LEN_BITS'(MAX_KMER_LEN)) r = LEN_BITS'(MAX_KMER_LEN);
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hdl/kmc_front.sv
// kmc_front: accepts items, keeps the rolling k-mer window and the length
// register, and queues counted k-mers, queries and clears. Depends on kmc_pkg.
`default_nettype none
module kmc_front import kmc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  accept,
  input  wire logic [1:0]            in_req_type,
  input  wire logic [7:0]            in_base_char,
  input  wire logic [INDEX_BITS-1:0] in_bucket_index,
  input  wire logic                  cfg_write,
  input  wire logic [LEN_BITS-1:0]   cfg_kmer_len,
  output logic                       push,
  output kmc_op_t                    push_op
);

  logic [LEN_BITS-1:0]   kmer_len_r;
  logic [INDEX_BITS-1:0] rolling_r, rolling_nxt;
  logic [LEN_BITS-1:0]   fill_r, fill_nxt;
  logic [2:0]            code;
  logic [LEN_BITS-1:0]   k;
  logic [INDEX_BITS-1:0] mask;
  logic [INDEX_BITS-1:0] shifted;

  // hold the length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kmer_len_r <= KMER_LEN_RESET;
    end else if (cfg_write) begin
      kmer_len_r <= cfg_kmer_len;
    end
  end

  assign code    = base_code(in_base_char);
  assign k       = eff_len(kmer_len_r);
  assign mask    = {INDEX_BITS{1'b1}} >> (INDEX_BITS'(INDEX_BITS) - INDEX_BITS'({k, 1'b0}));
  assign shifted = {rolling_r[INDEX_BITS-3:0], code[1:0]};

  // advance the window and classify the item
  always_comb begin
    rolling_nxt  = rolling_r;
    fill_nxt     = fill_r;
    push         = 1'b0;
    push_op.op   = OP_COUNT;
    push_op.addr = in_bucket_index;
    if (accept) begin
      case (in_req_type)
        REQ_BASE: begin
          if (code[2]) begin
            rolling_nxt = '0;
            fill_nxt    = LEN_BITS'(1);
          end else if (fill_r >= k) begin
            rolling_nxt  = shifted & mask;
            push         = 1'b1;
            push_op.op   = OP_COUNT;
            push_op.addr = shifted & mask;
          end else begin
            rolling_nxt = shifted;
            fill_nxt    = fill_r + LEN_BITS'(1);
          end
        end
        REQ_QUERY: begin
          push       = 1'b1;
          push_op.op = OP_QUERY;
        end
        REQ_CLEAR: begin
          rolling_nxt = '0;
          fill_nxt    = LEN_BITS'(1);
          push        = 1'b1;
          push_op.op  = OP_CLEAR;
        end
        default: begin
          push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rolling_r <= '0;
      fill_r    <= LEN_BITS'(1);
    end else begin
      rolling_r <= rolling_nxt;
      fill_r    <= fill_nxt;
    end
  end

endmodule
`default_nettype wire

// File: hdl/kmc_queue.sv
// kmc_queue: short operation queue between front and back.
// Depends on kmc_pkg.
`default_nettype none
module kmc_queue import kmc_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire kmc_op_t push_op,
  input  wire logic    pop,
  output kmc_op_t      head_op,
  output logic         not_empty,
  output logic         full
);

  kmc_op_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_BITS:0]   count_r;

  assign head_op   = slot_r[rd_ptr_r];
  assign not_empty = (count_r != '0);
  assign full      = (count_r == (QPTR_BITS+1)'(QUEUE_DEPTH));

  // store pushed words
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_op;
    end
  end

  // advance pointers and track the fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_BITS'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QPTR_BITS'(1);
      case ({push, pop})
        2'b10:   count_r <= count_r + (QPTR_BITS+1)'(1);
        2'b01:   count_r <= count_r - (QPTR_BITS+1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: hdl/kmc_back.sv
// kmc_back: count table memory with read-modify-write, queries, distinct
// tally and clearing sweeps. Depends on kmc_pkg.
`default_nettype none
module kmc_back import kmc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire kmc_op_t               head_op,
  input  wire logic                  not_empty,
  output logic                       pop,
  output logic                       out_strobe,
  output logic [COUNT_BITS-1:0]      out_bucket_count,
  output logic [TALLY_BITS-1:0]      out_distinct_kmers,
  output kmc_back_stat_t             stat
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EXEC  = 2'd1;
  localparam logic [1:0] ST_SWEEP = 2'd2;
  localparam int TABLE_DEPTH = 1 << INDEX_BITS;

  logic [COUNT_BITS-1:0] mem [TABLE_DEPTH];
  logic [COUNT_BITS-1:0] rdata_r;
  logic [1:0]            state_r, state_nxt;
  logic [1:0]            op_r;
  logic [INDEX_BITS-1:0] addr_r;
  logic [INDEX_BITS-1:0] ptr_r;
  logic                  init_r;
  logic [TALLY_BITS-1:0] tally_r;
  logic                  mem_we;
  logic [INDEX_BITS-1:0] mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata;
  logic                  strobe_r;
  logic [COUNT_BITS-1:0] count_out_r;
  logic [TALLY_BITS-1:0] tally_out_r;

  assign pop = (state_r == ST_IDLE) && not_empty;

  // pick the memory write: sweep zero or saturating increment
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_r;
    mem_wdata = rdata_r + COUNT_BITS'(1);
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (pop) begin
          state_nxt = (head_op.op == OP_CLEAR) ? ST_SWEEP : ST_EXEC;
        end
      end
      ST_EXEC: begin
        mem_we    = (op_r == OP_COUNT) && (rdata_r != COUNT_MAX);
        state_nxt = ST_IDLE;
      end
      ST_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_r;
        mem_wdata = '0;
        if (ptr_r == {INDEX_BITS{1'b1}}) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // table memory with registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[head_op.addr];
  end

  // hold the operation in flight
  always_ff @(posedge clk) begin
    if (pop) begin
      op_r   <= head_op.op;
      addr_r <= head_op.addr;
    end
  end

  // control: state, sweep pointer, tally, result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_SWEEP;
      ptr_r    <= '0;
      init_r   <= 1'b1;
      tally_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= 1'b0;
      if (pop && head_op.op == OP_CLEAR) begin
        ptr_r   <= '0;
        tally_r <= '0;
      end
      if (state_r == ST_SWEEP) begin
        ptr_r <= ptr_r + INDEX_BITS'(1);
        if (ptr_r == {INDEX_BITS{1'b1}}) init_r <= 1'b0;
      end
      if (state_r == ST_EXEC) begin
        if (op_r == OP_COUNT && rdata_r == '0) tally_r <= tally_r + TALLY_BITS'(1);
        if (op_r == OP_QUERY) strobe_r <= 1'b1;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (state_r == ST_EXEC && op_r == OP_QUERY) begin
      count_out_r <= rdata_r;
      tally_out_r <= tally_r;
    end
  end

  assign out_strobe          = strobe_r;
  assign out_bucket_count    = count_out_r;
  assign out_distinct_kmers  = tally_out_r;
  assign stat.init_sweep     = init_r;
  assign stat.sweeping       = (state_r == ST_SWEEP);

endmodule
`default_nettype wire

// File: hdl/kmer_occurrence_counter.sv
// kmer_occurrence_counter: top level joining front, queue and back.
// Depends on kmc_pkg, kmc_front, kmc_queue, kmc_back.
//
//  channel  ports                                   handshake
//  in       in_req_type, in_base_char, in_bucket_index  start && !busy
//  out      out_bucket_count, out_distinct_kmers    out_strobe, one cycle
//  cfg      cfg_kmer_len                            cfg_valid && cfg_ready
//
// A base that only fills the window stays in the front. Counts and queries go
// through a four-word queue to the back, which handles each in two steps
// (registered memory read, then write or result); a query result is registered.
// A clear sweeps the 65536-entry table at one entry a cycle.
// After reset the same sweep runs with busy high.
// busy rises when the queue is full; the result side cannot stall.
`default_nettype none
module kmer_occurrence_counter import kmc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [1:0]            in_req_type,
  input  wire logic [7:0]            in_base_char,
  input  wire logic [INDEX_BITS-1:0] in_bucket_index,
  output logic                       out_strobe,
  output logic [COUNT_BITS-1:0]      out_bucket_count,
  output logic [TALLY_BITS-1:0]      out_distinct_kmers,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [LEN_BITS-1:0]   cfg_kmer_len
);

  logic           accept;
  logic           push;
  kmc_op_t        push_op;
  logic           pop;
  kmc_op_t        head_op;
  logic           not_empty;
  logic           full;
  kmc_back_stat_t stat;

  // stall intake while the queue is full or the reset sweep runs
  assign busy      = full || stat.init_sweep;
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  kmc_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .in_req_type     (in_req_type),
    .in_base_char    (in_base_char),
    .in_bucket_index (in_bucket_index),
    .cfg_write       (cfg_valid && cfg_ready),
    .cfg_kmer_len    (cfg_kmer_len),
    .push            (push),
    .push_op         (push_op)
  );

  kmc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_op   (push_op),
    .pop       (pop),
    .head_op   (head_op),
    .not_empty (not_empty),
    .full      (full)
  );

  kmc_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head_op            (head_op),
    .not_empty          (not_empty),
    .pop                (pop),
    .out_strobe         (out_strobe),
    .out_bucket_count   (out_bucket_count),
    .out_distinct_kmers (out_distinct_kmers),
    .stat               (stat)
  );

  // results are spaced by the back's read and exec steps
  a_strobe_spaced: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("back strobed results on adjacent cycles");

  // no result while the table is being cleared
  a_no_result_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    stat.sweeping |=> !out_strobe)
    else $error("result strobed during a clearing sweep");

  // the tally can never pass the number of buckets
  a_tally_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_distinct_kmers <= TALLY_BITS'(1 << INDEX_BITS))
    else $error("distinct tally beyond table size");

  // never push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("queue overflow");

endmodule
`default_nettype wire

// File: tb/tb.sv
// tb: self-checking bench for kmer_occurrence_counter; a directed table, then phases
// of random base streams and queries at several k-mer lengths.
// Depends on kmc_pkg and the kmer_occurrence_counter RTL.
`timescale 1ns / 1ps
module tb;
  import kmc_pkg::*;

  localparam logic [1:0] REQ_UNUSED   = 2'd3;
  localparam logic [7:0] CH_A         = 8'h41;
  localparam logic [7:0] CH_C         = 8'h43;
  localparam logic [7:0] CH_G         = 8'h47;
  localparam logic [7:0] CH_T         = 8'h54;
  localparam logic [7:0] BASE_CHARS [4] = '{CH_A, CH_C, CH_G, CH_T};
  localparam logic [2:0] NOT_A_BASE   = 3'd4;
  localparam int         SETTLE_CYCLES = 32;
  localparam int         CYCLE_LIMIT   = 3_000_000;
  localparam int         PHASES        = 10;
  localparam int         PHASE_WORDS   = 109;
  localparam logic [3:0] PHASE_LEN [PHASES] = '{4'd1, 4'd8, 4'd2, 4'd0, 4'd5,
                                               4'd15, 4'd3, 4'd7, 4'd4, 4'd6};

  typedef struct packed {
    logic [COUNT_BITS-1:0] bucket_count;
    logic [TALLY_BITS-1:0] distinct_kmers;
  } answer_t;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [1:0]            req;
    logic [7:0]            ch;
    logic [INDEX_BITS-1:0] idx;
    logic [LEN_BITS-1:0]   len;
    bit                    typed;
    logic [COUNT_BITS-1:0] cnt;
    logic [TALLY_BITS-1:0] tally;
  } script_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [1:0]            in_req_type = REQ_BASE;
  logic [7:0]            in_base_char = 8'h00;
  logic [INDEX_BITS-1:0] in_bucket_index = '0;
  logic                  out_strobe;
  logic [COUNT_BITS-1:0] out_bucket_count;
  logic [TALLY_BITS-1:0] out_distinct_kmers;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [LEN_BITS-1:0]   cfg_kmer_len = KMER_LEN_RESET;

  // predicted state of the block
  bit [COUNT_BITS-1:0]   bucket_counts [1 << INDEX_BITS];
  logic [INDEX_BITS-1:0] rolling_code = '0;
  logic [3:0]            bases_in_window = 4'd1;
  logic [TALLY_BITS-1:0] distinct_seen = '0;
  logic [LEN_BITS-1:0]   kmer_len_cfg = KMER_LEN_RESET;
  logic [INDEX_BITS-1:0] recent_hits [8];
  int                    recent_ptr = 0;

  answer_t     pending_answers [$];
  script_row_t script [31];
  int          mismatches = 0;
  int          cycles = 0;
  bit          gaps_on = 1'b1;

  kmer_occurrence_counter dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // effective k: clamp to 1..MAX_KMER_LEN
  function automatic logic [3:0] window_len();
    logic [3:0] k;
    k = kmer_len_cfg;
    if (k == 4'd0) k = 4'd1;
    if (k > MAX_KMER_LEN) k = 4'(MAX_KMER_LEN);
    return k;
  endfunction

  // advance the predicted state by one word; a query yields an answer
  function automatic void update_kmer_counts(input logic [1:0] req, input logic [7:0] ch,
                                             input logic [INDEX_BITS-1:0] idx,
                                             output bit answers, output answer_t ans);
    logic [2:0]            code;
    logic [3:0]            k;
    logic [INDEX_BITS-1:0] mask;
    answers = 1'b0;
    ans = '0;
    case (req)
      REQ_BASE: begin
        case (ch)
          CH_A:    code = 3'd0;
          CH_C:    code = 3'd1;
          CH_G:    code = 3'd2;
          CH_T:    code = 3'd3;
          default: code = NOT_A_BASE;
        endcase
        k = window_len();
        mask = 16'hffff >> (16 - 2 * k);
        if (code == NOT_A_BASE) begin
          // restart the window
          bases_in_window = 4'd1;
          rolling_code = '0;
        end else if (bases_in_window >= k) begin
          rolling_code = ((rolling_code << 2) | code) & mask;
          if (bucket_counts[rolling_code] == '0) distinct_seen = distinct_seen + 1'b1;
          if (bucket_counts[rolling_code] != COUNT_MAX)
            bucket_counts[rolling_code] = bucket_counts[rolling_code] + 1'b1;
          recent_hits[recent_ptr] = rolling_code;
          recent_ptr = (recent_ptr + 1) % 8;
        end else begin
          bases_in_window = bases_in_window + 1'b1;
          rolling_code = (rolling_code << 2) | code;
        end
      end
      REQ_QUERY: begin
        answers = 1'b1;
        ans.bucket_count = bucket_counts[idx];
        ans.distinct_kmers = distinct_seen;
      end
      REQ_CLEAR: begin
        foreach (bucket_counts[i]) bucket_counts[i] = '0;
        rolling_code = '0;
        bases_in_window = 4'd1;
        distinct_seen = '0;
      end
      default: ;
    endcase
  endfunction

  // drive one word, wait for it to be taken, then predict its answer
  task automatic send_word(input logic [1:0] req, input logic [7:0] ch,
                           input logic [INDEX_BITS-1:0] idx, input bit typed,
                           input logic [COUNT_BITS-1:0] t_cnt,
                           input logic [TALLY_BITS-1:0] t_tally);
    answer_t ans;
    bit      answers;
    if (gaps_on) begin
      while ($urandom_range(0, 99) < 27) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start <= 1'b1;
    in_req_type <= req;
    in_base_char <= ch;
    in_bucket_index <= idx;
    @(posedge clk);
    while (busy) @(posedge clk);
    update_kmer_counts(req, ch, idx, answers, ans);
    if (answers) begin
      if (typed) begin
        ans.bucket_count = t_cnt;
        ans.distinct_kmers = t_tally;
      end
      pending_answers.push_back(ans);
    end
  endtask

  // write kmer_len once the block is idle; the word before is always a query,
  // so its answer proves that any clear sweep ahead of it has finished
  task automatic write_kmer_len(input logic [LEN_BITS-1:0] len);
    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_kmer_len <= len;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    kmer_len_cfg = len;
  endtask

  function automatic script_row_t r_row(input logic [1:0] req, input logic [7:0] ch,
                                        input logic [INDEX_BITS-1:0] idx);
    script_row_t r;
    r = '{ROW_WORD, req, ch, idx, '0, 1'b0, '0, '0};
    return r;
  endfunction

  function automatic script_row_t b_row(input logic [7:0] ch);
    return r_row(REQ_BASE, ch, '0);
  endfunction

  function automatic script_row_t q_row(input logic [INDEX_BITS-1:0] idx);
    return r_row(REQ_QUERY, 8'h00, idx);
  endfunction

  function automatic script_row_t qx_row(input logic [INDEX_BITS-1:0] idx,
                                         input logic [COUNT_BITS-1:0] cnt,
                                         input logic [TALLY_BITS-1:0] tally);
    script_row_t r;
    r = '{ROW_WORD, REQ_QUERY, 8'h00, idx, '0, 1'b1, cnt, tally};
    return r;
  endfunction

  function automatic script_row_t c_row(input logic [LEN_BITS-1:0] len);
    script_row_t r;
    r = '{ROW_CFG, REQ_BASE, 8'h00, '0, len, 1'b0, '0, '0};
    return r;
  endfunction

  // check each answer against the oldest prediction
  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_strobe) begin
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected answer: count %0d distinct %0d",
                   out_bucket_count, out_distinct_kmers);
      end else begin
        want = pending_answers.pop_front();
        if (out_bucket_count !== want.bucket_count ||
            out_distinct_kmers !== want.distinct_kmers) begin
          mismatches++;
          if (mismatches <= 10)
            $display("answer mismatch: count exp %0d got %0d, distinct exp %0d got %0d",
                     want.bucket_count, out_bucket_count,
                     want.distinct_kmers, out_distinct_kmers);
        end
      end
    end
  end

  // stop a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int                    pick;
    logic [1:0]            req;
    logic [7:0]            ch;
    logic [INDEX_BITS-1:0] idx;
    logic [LEN_BITS-1:0]   len;
    foreach (recent_hits[i]) recent_hits[i] = '0;

    // directed words: empty table, short k, restarts, length changes, clear
    script = '{
      qx_row(16'h0000, '0, '0), qx_row(16'hffff, '0, '0),
      c_row(4'd2),
      b_row(CH_A), b_row(CH_C), b_row(CH_G), b_row(CH_T),
      b_row(8'h61),  // lowercase is not a base
      b_row(CH_C), b_row(CH_A),
      r_row(REQ_UNUSED, CH_G, 16'h5a5a),
      b_row(CH_A), q_row(16'h0000),
      q_row(16'h00ff),  // beyond 4^k
      c_row(4'd8),      // longer k with a partly filled window
      b_row(CH_G), b_row(CH_G), b_row(CH_T), q_row(16'h0003),
      c_row(4'd3),      // shorter k: window already counts as full
      b_row(CH_A), b_row(8'h00), q_row(16'h002c),
      c_row(4'd0),      // clamps to one base
      b_row(CH_T), b_row(8'hff), b_row(CH_T), q_row(16'h0003),
      c_row(4'd15),     // clamps to the longest k
      r_row(REQ_CLEAR, 8'hff, 16'hffff),
      qx_row(16'h0003, '0, '0)
    };

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      if (script[i].kind == ROW_CFG) begin
        write_kmer_len(script[i].len);
      end else begin
        send_word(script[i].req, script[i].ch, script[i].idx, script[i].typed,
                  script[i].cnt, script[i].tally);
      end
    end

    // random phases: mostly clean base runs with queries, some noise
    for (int p = 0; p < PHASES; p++) begin
      len = (p == PHASES - 1) ? LEN_BITS'($urandom_range(0, 15)) : PHASE_LEN[p];
      write_kmer_len(len);
      gaps_on = (p != 4);
      if (p % 3 == 2)
        send_word(REQ_CLEAR, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                  1'b0, '0, '0);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        pick = $urandom_range(0, 99);
        req = REQ_BASE;
        ch = 8'($urandom_range(0, 255));
        idx = 16'($urandom_range(0, 65535));
        if (pick < 65 || pick >= 92) begin
          ch = BASE_CHARS[$urandom_range(0, 3)];
        end else if (pick >= 70 && pick < 90) begin
          req = REQ_QUERY;
          if (pick < 82) idx = recent_hits[$urandom_range(0, 7)];
          else if (pick < 87) idx = idx & (16'hffff >> (16 - 2 * window_len()));
        end else if (pick >= 90) begin
          req = REQ_UNUSED;
        end
        send_word(req, ch, idx, 1'b0, '0, '0);
      end
      // close the phase with a query so its answer marks the block idle
      send_word(REQ_QUERY, 8'($urandom_range(0, 255)), recent_hits[$urandom_range(0, 7)],
                1'b0, '0, '0);
    end

    // drain and report
    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_answers.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
